[hdl/mqwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqwm_pkg: shared types and codes
// Operation kinds, status codes and the cell control struct.
// ----------------------------------------------------------------------------
package mqwm_pkg;

    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_DEQ   = 2'd1,
        KIND_FIND  = 2'd2,
        KIND_CHECK = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    localparam int IN_ID_W  = 16;
    localparam int IN_Q_W   = 3;
    localparam int OUT_CNT_W = 5;

    // control from the sequencer to every queue cell
    typedef struct packed {
        logic       scan;     // compare this cycle
        logic       clear;    // clear match flags
        logic       push;     // append the search id to the selected cell
        logic       pop;      // drop the head of the selected cell
        logic       open;     // mark the selected cell open
        logic [5:0] sel;      // selected queue
    } cell_ctrl_t;

endpackage

[hdl/mqwm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqwm_if: valid/ready channel
// Carries one word per handshake with a generic payload.
// ----------------------------------------------------------------------------
interface mqwm_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/mqwm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqwm_cell: one queue held as a rotating shift line
// Entries rotate one slot a cycle during a scan; the entry at the head end
// is compared with the search id, so a full rotation visits every slot.
// ----------------------------------------------------------------------------
module mqwm_cell
    import mqwm_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cell_ctrl_t                     ctrl,
    input  logic [ID_BITS-1:0]             search_id,
    output logic                           open,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
    output logic                           match,
    output logic [ID_BITS-1:0]             head
);
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [ID_BITS-1:0] slot_reg [QUEUE_DEPTH];
    logic [CW-1:0]      count_reg, count_next;
    logic [PW-1:0]      pos_reg;
    logic               open_reg, match_reg;
    logic               me;

    assign me    = (ctrl.sel == 6'(IDX));
    assign open  = open_reg;
    assign count = count_reg;
    assign match = match_reg;
    assign head  = slot_reg[0];

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (me && ctrl.push)
            count_next = count_reg + CW'(1);
        else if (me && ctrl.pop)
            count_next = count_reg - CW'(1);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= '0;
            match_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (me && ctrl.open)
                open_reg <= 1'b1;
            if (ctrl.clear)
            begin
                match_reg <= 1'b0;
                pos_reg   <= '0;
            end
            else if (ctrl.scan)
            begin
                if (open_reg && ({1'b0, pos_reg} < count_reg) && slot_reg[0] == search_id)
                    match_reg <= 1'b1;
                pos_reg <= (pos_reg == PW'(QUEUE_DEPTH-1)) ? '0 : pos_reg + PW'(1);
            end
        end
    end

    // entry line: rotate on scan, shift out on pop, write tail on push
    always_ff @(posedge clk)
    begin
        if (ctrl.scan)
        begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
                slot_reg[k] <= slot_reg[(k+1) % QUEUE_DEPTH];
        end
        else if (me && ctrl.pop)
        begin
            for (int k = 0; k < QUEUE_DEPTH-1; k++)
                slot_reg[k] <= slot_reg[k+1];
        end
        else if (me && ctrl.push)
        begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
                if (CW'(k) == count_reg)
                    slot_reg[k] <= search_id;
        end
    end
endmodule

[hdl/multi_queue_waitlist_manager_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_waitlist_manager_top: queue manager top level
// Each queue is a cell holding its entries in a rotating shift line. An
// enqueue or membership query rotates every cell through all QUEUE_DEPTH slots
// while each compares its head slot; dequeue and check skip that pass. A
// second pass walks the cells in turn to find the longest open queue. The
// input is ready again once the result is stored, so a new word is taken
// only when the previous one is through. While a stored result is not
// taken, the next word is processed but waits before its result is stored,
// and the input stays closed until then.
// ----------------------------------------------------------------------------
module multi_queue_waitlist_manager_top
    import mqwm_pkg::*;
#(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
)(
    input logic  clk,
    input logic  rst_n,
    mqwm_if.sink   in_ch,
    mqwm_if.source out_ch
);
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW = $clog2(QUEUE_DEPTH+1);
    localparam int NW = $clog2(NUM_QUEUES+1);
    localparam int OW = IN_ID_W + IN_Q_W + OUT_CNT_W + 5;

    typedef enum logic [2:0] {S_IDLE, S_CLR, S_SCAN, S_ACT, S_BEST, S_OUT} state_t;

    state_t             state_reg;
    kind_t              kind_reg;
    logic [IN_Q_W-1:0]  q_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [SW-1:0]      step_reg;
    logic [NW-1:0]      walk_reg;
    status_t            status_reg;
    logic [ID_BITS-1:0] removed_reg;
    logic               wait_reg, any_reg;
    logic [QW-1:0]      best_q_reg;
    logic [CW-1:0]      best_n_reg;
    logic               out_valid_reg;
    logic [OW-1:0]      out_data_reg;

    cell_ctrl_t         ctrl;
    logic [NUM_QUEUES-1:0] c_open, c_match;
    logic [CW-1:0]      c_count [NUM_QUEUES];
    logic [ID_BITS-1:0] c_head  [NUM_QUEUES];
    logic               known;
    logic [QW-1:0]      qi, wi;

    assign known = ({3'b0, q_reg} < 6'(NUM_QUEUES));
    assign qi    = QW'(q_reg);
    assign wi    = QW'(walk_reg);

    // row of queue cells
    for (genvar g = 0; g < NUM_QUEUES; g++)
    begin : g_cell
        mqwm_cell #(.IDX(g), .QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_cell (
            .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .search_id(id_reg),
            .open(c_open[g]), .count(c_count[g]), .match(c_match[g]),
            .head(c_head[g])
        );
    end

    // cell control
    always_comb
    begin
        ctrl       = '0;
        ctrl.sel   = known ? 6'(q_reg) : 6'h3f;
        ctrl.clear = (state_reg == S_CLR);
        ctrl.scan  = (state_reg == S_SCAN);
        if (state_reg == S_ACT && known)
        begin
            case (kind_reg)
                KIND_ENQ:
                begin
                    ctrl.open = 1'b1;
                    ctrl.push = !c_match[qi] && (c_count[qi] < CW'(QUEUE_DEPTH));
                end
                KIND_DEQ:
                    ctrl.pop = c_open[qi] && (c_count[qi] != '0);
                default: ;
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            walk_reg      <= '0;
            any_reg       <= 1'b0;
            kind_reg      <= KIND_ENQ;
            q_reg         <= '0;
            id_reg        <= '0;
            status_reg    <= ST_OK;
            removed_reg   <= '0;
            wait_reg      <= 1'b0;
            best_q_reg    <= '0;
            best_n_reg    <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        kind_reg  <= kind_t'(in_ch.data[IN_Q_W+IN_ID_W +: 2]);
                        q_reg     <= in_ch.data[IN_ID_W +: IN_Q_W];
                        id_reg    <= ID_BITS'(in_ch.data[IN_ID_W-1:0]);
                        state_reg <= S_CLR;
                    end
                S_CLR:
                begin
                    step_reg  <= '0;
                    state_reg <= (kind_reg == KIND_ENQ || kind_reg == KIND_FIND) ? S_SCAN : S_ACT;
                end
                S_SCAN:
                begin
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(QUEUE_DEPTH-1))
                        state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    status_reg  <= ST_OK;
                    removed_reg <= '0;
                    wait_reg    <= 1'b0;
                    case (kind_reg)
                        KIND_ENQ:
                            if (!known) status_reg <= ST_UNKNOWN;
                            else if (c_match[qi]) status_reg <= ST_DUP;
                            else if (c_count[qi] >= CW'(QUEUE_DEPTH)) status_reg <= ST_FULL;
                        KIND_DEQ:
                            if (!known || !c_open[qi]) status_reg <= ST_UNKNOWN;
                            else if (c_count[qi] == '0) status_reg <= ST_EMPTY;
                            else removed_reg <= c_head[qi];
                        KIND_FIND:
                            wait_reg <= |c_match;
                        KIND_CHECK:
                            if (!known || !c_open[qi]) status_reg <= ST_UNKNOWN;
                            else if (c_count[qi] == '0) status_reg <= ST_EMPTY;
                            else wait_reg <= 1'b1;
                        default: ;
                    endcase
                    walk_reg   <= '0;
                    any_reg    <= 1'b0;
                    best_q_reg <= '0;
                    best_n_reg <= '0;
                    state_reg  <= S_BEST;
                end
                S_BEST:
                begin
                    if (c_open[wi] && (!any_reg || c_count[wi] > best_n_reg))
                    begin
                        any_reg    <= 1'b1;
                        best_q_reg <= wi;
                        best_n_reg <= c_count[wi];
                    end
                    walk_reg <= walk_reg + NW'(1);
                    if (walk_reg == NW'(NUM_QUEUES-1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {status_reg, IN_ID_W'(removed_reg), wait_reg,
                                          any_reg, IN_Q_W'(best_q_reg),
                                          OUT_CNT_W'(best_n_reg)};
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // no new word is taken while a search is under way
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == S_IDLE)) else $error("ready outside idle");
    // a dequeue never reports a removed id together with an error
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_data_reg[OW-1 -: 3] != ST_OK) |->
        (out_data_reg[OW-4 -: IN_ID_W] == '0)) else $error("removed id on error");
    // a busiest count without an open queue cannot happen
    a_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !any_reg) |-> (best_n_reg == '0)) else $error("count without queue");
endmodule

[bench/multi_queue_waitlist_manager_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_waitlist_manager_top_tb: queue manager testbench
// Drives enqueue, dequeue, membership and queue check words through the
// valid/ready channels. A scoreboard keeps its own copy of every queue,
// predicts each result word and compares it field by field. Both sides
// idle at random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module multi_queue_waitlist_manager_top_tb;
    import mqwm_pkg::*;

    localparam int NQ         = 8;
    localparam int DEPTH      = 16;
    localparam int IN_W       = 21;
    localparam int OUT_W      = 29;
    localparam int RAND_WORDS = 1430;
    localparam int MAX_CYCLES = 600000;

    // result word layout, first field in the top bits
    typedef struct packed {
        status_t     status;
        logic [15:0] removed_id;
        logic        is_waiting;
        logic        busiest_valid;
        logic [2:0]  busiest_queue;
        logic [4:0]  busiest_count;
    } result_t;

    // queue manager predictor and store of expected result words
    class queue_scoreboard;
        logic [15:0] slots [NQ][DEPTH];
        logic [3:0]  head [NQ];
        logic [4:0]  occ [NQ];
        bit          opened [NQ];
        result_t     expected_q [$];
        int          errors;
        int          status_seen [5];
        int          checked;

        function new();
            for (int i = 0; i < NQ; i++)
            begin
                head[i]   = '0;
                occ[i]    = '0;
                opened[i] = 0;
            end
            errors  = 0;
            checked = 0;
            for (int i = 0; i < 5; i++)
                status_seen[i] = 0;
        endfunction

        function bit holds(int q, logic [15:0] id);
            for (int k = 0; k < occ[q]; k++)
                if (slots[q][(head[q] + k) % DEPTH] == id)
                    return 1;
            return 0;
        endfunction

        // predict the result of one accepted input word
        function void note_word(kind_t kind, logic [2:0] q, logic [15:0] id);
            result_t r;
            r = '0;
            r.status = ST_OK;
            case (kind)
                KIND_ENQ:
                begin
                    opened[q] = 1;
                    if (holds(q, id))
                        r.status = ST_DUP;
                    else if (occ[q] >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        slots[q][(head[q] + occ[q]) % DEPTH] = id;
                        occ[q]++;
                    end
                end
                KIND_DEQ:
                begin
                    if (!opened[q])
                        r.status = ST_UNKNOWN;
                    else if (occ[q] == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.removed_id = slots[q][head[q]];
                        head[q]++;
                        occ[q]--;
                    end
                end
                KIND_FIND:
                begin
                    for (int i = 0; i < NQ; i++)
                        if (opened[i] && holds(i, id))
                            r.is_waiting = 1;
                end
                default:
                begin
                    if (!opened[q])
                        r.status = ST_UNKNOWN;
                    else if (occ[q] == 0)
                        r.status = ST_EMPTY;
                    else
                        r.is_waiting = 1;
                end
            endcase
            // longest open queue, lowest index on ties
            for (int i = 0; i < NQ; i++)
            begin
                if (opened[i] && (!r.busiest_valid || occ[i] > r.busiest_count))
                begin
                    r.busiest_valid = 1;
                    r.busiest_queue = i[2:0];
                    r.busiest_count = occ[i];
                end
            end
            status_seen[r.status]++;
            expected_q.push_back(r);
        endfunction

        // compare one result word with the oldest expectation
        function void check_word(logic [OUT_W-1:0] data);
            result_t got;
            result_t exp;
            got = result_t'(data);
            if (expected_q.size() == 0)
            begin
                $error("result word with no expectation: %h", data);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.removed_id !== exp.removed_id)
            begin
                $error("removed_id: expected %h, actual %h", exp.removed_id,
                       got.removed_id);
                errors++;
            end
            if (got.is_waiting !== exp.is_waiting)
            begin
                $error("is_waiting: expected %b, actual %b", exp.is_waiting,
                       got.is_waiting);
                errors++;
            end
            if (got.busiest_valid !== exp.busiest_valid)
            begin
                $error("busiest_valid: expected %b, actual %b", exp.busiest_valid,
                       got.busiest_valid);
                errors++;
            end
            if (got.busiest_queue !== exp.busiest_queue)
            begin
                $error("busiest_queue: expected %0d, actual %0d", exp.busiest_queue,
                       got.busiest_queue);
                errors++;
            end
            if (got.busiest_count !== exp.busiest_count)
            begin
                $error("busiest_count: expected %0d, actual %0d", exp.busiest_count,
                       got.busiest_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    bit   idle_on;
    logic [15:0] id_pool [16];

    mqwm_if #(.W(IN_W))  in_ch ();
    mqwm_if #(.W(OUT_W)) out_ch ();

    queue_scoreboard sb = new();

    multi_queue_waitlist_manager_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // offer one input word and wait for its acceptance
    task automatic send_word(kind_t kind, logic [2:0] q, logic [15:0] id);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {kind, q, id};
        forever
        begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        sb.note_word(kind, q, id);
    endtask

    // receiver: random stalls, one long hold-off after some traffic
    initial
    begin
        int wait_n;
        bit held;
        held = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && sb.checked >= 300)
            begin
                held = 1;
                out_ch.ready <= 1'b0;
                repeat (500) @(negedge clk);
            end
            wait_n = idle_on ? $urandom_range(0, 6) : 0;
            if (wait_n > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (out_ch.valid)
                    break;
            end
            sb.check_word(out_ch.data);
        end
    end

    // stimulus
    initial
    begin
        kind_t       k;
        logic [2:0]  q;
        logic [15:0] id;
        int          pick;
        cycles      = 0;
        idle_on     = 1;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        for (int i = 0; i < 16; i++)
            id_pool[i] = 16'($urandom);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: closed queue, field extremes, full and duplicate cases
        send_word(KIND_DEQ, 3'd7, 16'h0000);
        send_word(KIND_CHECK, 3'd0, 16'h0000);
        send_word(KIND_FIND, 3'd0, 16'hFFFF);
        send_word(KIND_ENQ, 3'd7, 16'hFFFF);
        send_word(KIND_ENQ, 3'd7, 16'hFFFF);
        send_word(KIND_ENQ, 3'd0, 16'h0000);
        send_word(KIND_FIND, 3'd3, 16'hFFFF);
        send_word(KIND_CHECK, 3'd7, 16'h0000);
        for (int i = 0; i < DEPTH; i++)
            send_word(KIND_ENQ, 3'd1, 16'(16'h1000 + i));
        send_word(KIND_ENQ, 3'd1, 16'h1003);
        send_word(KIND_ENQ, 3'd1, 16'h5555);
        send_word(KIND_DEQ, 3'd7, 16'h0000);
        send_word(KIND_DEQ, 3'd7, 16'h0000);
        send_word(KIND_CHECK, 3'd7, 16'h0000);

        // random: mostly a few busy queues, small id pool for duplicates
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                k = KIND_ENQ;
            else if (pick < 75)
                k = KIND_DEQ;
            else if (pick < 88)
                k = KIND_FIND;
            else
                k = KIND_CHECK;
            q = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
            id = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : id_pool[$urandom_range(0, 15)];
            send_word(k, q, id);
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;

        // drain and let the pipeline settle
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("checked %0d result words: ok %0d, duplicate %0d, empty %0d",
                 sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_DUP],
                 sb.status_seen[ST_EMPTY]);
        $display("full %0d, unknown queue %0d, one long output stall included",
                 sb.status_seen[ST_FULL], sb.status_seen[ST_UNKNOWN]);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
